@@ sv/uapq_pkg.sv @@
// Shared types, codes and the control store for the unsorted-array priority queue.
// Depends on nothing; used by unsorted_array_priority_queue_top.
package uapq_pkg;

    // Command codes carried by each request.
    typedef enum logic [1:0] {
        CMD_ADD         = 2'd0,
        CMD_EXTRACT_MAX = 2'd1,
        CMD_EXTRACT_ALL = 2'd2,
        CMD_CONTAINS    = 2'd3
    } cmd_t;

    // Result status codes.
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_EXTRACTED = 3'd3;
    localparam logic [2:0] ST_CONTAINS  = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    // One stored entry.
    typedef struct packed {
        logic signed [15:0] prio;
        logic [31:0]        value;
    } entry_t;

    // Micro-step addresses.
    typedef logic [3:0] step_t;
    localparam step_t STEP_IDLE       = 4'd0;
    localparam step_t STEP_ADD        = 4'd1;
    localparam step_t STEP_MAX_CHECK  = 4'd2;
    localparam step_t STEP_MAX_SCAN   = 4'd3;
    localparam step_t STEP_REWIND     = 4'd4;
    localparam step_t STEP_COMPACT    = 4'd5;
    localparam step_t STEP_FINISH     = 4'd6;
    localparam step_t STEP_SEARCH     = 4'd7;
    localparam step_t STEP_REPORT     = 4'd8;
    localparam step_t STEP_EMPTY      = 4'd9;

    // Datapath actions selected by a control word.
    typedef enum logic [3:0] {
        ACT_WAIT    = 4'd0,
        ACT_ADD     = 4'd1,
        ACT_NOP     = 4'd2,
        ACT_SCAN    = 4'd3,
        ACT_REWIND  = 4'd4,
        ACT_COMPACT = 4'd5,
        ACT_FINISH  = 4'd6,
        ACT_SEARCH  = 4'd7,
        ACT_REPORT  = 4'd8,
        ACT_EMPTY   = 4'd9
    } act_t;

    // Sequencing conditions.
    typedef enum logic [1:0] {
        COND_DISPATCH = 2'd0,
        COND_ALWAYS   = 2'd1,
        COND_WALK     = 2'd2,
        COND_EMPTY    = 2'd3
    } cond_t;

    // One control word: action, jump condition and jump target.
    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } uword_t;

    // The control program. A conditional jump falls through to the next step.
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        unique case (step)
            STEP_IDLE:      w = '{act: ACT_WAIT,    cond: COND_DISPATCH, target: STEP_IDLE};
            STEP_ADD:       w = '{act: ACT_ADD,     cond: COND_ALWAYS,   target: STEP_IDLE};
            STEP_MAX_CHECK: w = '{act: ACT_NOP,     cond: COND_EMPTY,    target: STEP_EMPTY};
            STEP_MAX_SCAN:  w = '{act: ACT_SCAN,    cond: COND_WALK,     target: STEP_MAX_SCAN};
            STEP_REWIND:    w = '{act: ACT_REWIND,  cond: COND_ALWAYS,   target: STEP_COMPACT};
            STEP_COMPACT:   w = '{act: ACT_COMPACT, cond: COND_WALK,     target: STEP_COMPACT};
            STEP_FINISH:    w = '{act: ACT_FINISH,  cond: COND_ALWAYS,   target: STEP_IDLE};
            STEP_SEARCH:    w = '{act: ACT_SEARCH,  cond: COND_WALK,     target: STEP_SEARCH};
            STEP_REPORT:    w = '{act: ACT_REPORT,  cond: COND_ALWAYS,   target: STEP_IDLE};
            STEP_EMPTY:     w = '{act: ACT_EMPTY,   cond: COND_ALWAYS,   target: STEP_IDLE};
            default:        w = '{act: ACT_NOP,     cond: COND_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Entry step of each command.
    function automatic step_t dispatch(input cmd_t cmd);
        step_t s;
        unique case (cmd)
            CMD_ADD:         s = STEP_ADD;
            CMD_EXTRACT_MAX: s = STEP_MAX_CHECK;
            CMD_EXTRACT_ALL: s = STEP_REWIND;
            CMD_CONTAINS:    s = STEP_SEARCH;
            default:         s = STEP_IDLE;
        endcase
        return s;
    endfunction

endpackage

@@ sv/unsorted_array_priority_queue_top.sv @@
// Top level of the unsorted-array priority queue: microcoded sequencer, entry memory, result port.
// Depends on uapq_pkg for types, codes and the control program.

// A request is taken when start is high and busy is low; busy stays high until the command
// has issued its final result. Results cannot be held off: each appears on the result ports
// for one cycle with result_valid high, and the final result of every command has last set.
// Entries live in a single-port-write, registered-read memory that the sequencer walks one
// entry per cycle. Extract-max makes a scan pass for the highest priority, then a compaction
// pass; extract-all and contains each make a single pass over the stored entries.
// Each entry removed by extract-all is reported when the walk reaches the next match, and the
// last one when the walk ends, so its results stream out during the compaction walk.
module unsorted_array_priority_queue_top #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [31:0] element_value,
    input  logic signed [15:0] priority_value,
    output logic               result_valid,
    output logic [2:0]         status,
    output logic signed [31:0] out_element,
    output logic signed [15:0] out_priority,
    output logic               found,
    output logic               last
);

    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Sequencer state.
    uapq_pkg::step_t  upc_reg, upc_next;
    uapq_pkg::uword_t uw;

    // Request registers.
    uapq_pkg::cmd_t     cmd_reg, cmd_next;
    logic [31:0]        val_reg, val_next;
    logic signed [15:0] prio_reg, prio_next;

    // Walk pointers and memory read stage.
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   kept_reg, kept_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    uapq_pkg::entry_t   rd_data_reg;

    // Scan, pending and search state.
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic signed [15:0] best_prio_reg, best_prio_next;
    logic               pend_reg, pend_next;
    uapq_pkg::entry_t   pend_data_reg, pend_data_next;
    logic               hit_reg, hit_next;

    // Result registers.
    logic               res_valid_reg, res_valid_next;
    logic [2:0]         status_reg, status_next;
    logic [31:0]        out_elem_reg, out_elem_next;
    logic signed [15:0] out_prio_reg, out_prio_next;
    logic               found_reg, found_next;
    logic               last_reg, last_next;

    // Memory ports.
    uapq_pkg::entry_t   mem_arr [QUEUE_DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    uapq_pkg::entry_t   mem_wdata;
    logic [AW-1:0]      rd_addr;

    logic               walk_more;
    logic               walk_busy;
    logic               remove;

    assign uw        = uapq_pkg::ucode_rom(upc_reg);
    assign walk_more = idx_reg < count_reg;
    assign walk_busy = walk_more || rd_valid_reg;
    assign rd_addr   = idx_reg[AW-1:0];

    // An entry is dropped by the compaction pass if it is the chosen maximum or matches.
    assign remove = (cmd_reg == uapq_pkg::CMD_EXTRACT_MAX) ? (rd_idx_reg == best_idx_reg)
                                                           : (rd_data_reg.prio == prio_reg);

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_arr[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem_arr[rd_addr];
    end

    // Step counter with conditional jumps.
    always_comb
    begin
        upc_next = upc_reg + 4'd1;
        unique case (uw.cond)
            uapq_pkg::COND_DISPATCH:
            begin
                upc_next = start ? uapq_pkg::dispatch(uapq_pkg::cmd_t'(command)) : upc_reg;
            end
            uapq_pkg::COND_ALWAYS:
            begin
                upc_next = uw.target;
            end
            uapq_pkg::COND_WALK:
            begin
                if (walk_busy)
                begin
                    upc_next = uw.target;
                end
            end
            uapq_pkg::COND_EMPTY:
            begin
                if (count_reg == '0)
                begin
                    upc_next = uw.target;
                end
            end
            default:
            begin
                upc_next = uapq_pkg::STEP_IDLE;
            end
        endcase
    end

    // Datapath driven by the action field of the control word.
    always_comb
    begin
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        prio_next      = prio_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        pend_next      = pend_reg;
        pend_data_next = pend_data_reg;
        hit_next       = hit_reg;
        res_valid_next = 1'b0;
        status_next    = uapq_pkg::ST_ADDED;
        out_elem_next  = '0;
        out_prio_next  = '0;
        found_next     = 1'b0;
        last_next      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = kept_reg[AW-1:0];
        mem_wdata      = rd_data_reg;

        // Walking actions issue one memory read per cycle while entries remain.
        if ((uw.act == uapq_pkg::ACT_SCAN || uw.act == uapq_pkg::ACT_COMPACT ||
             uw.act == uapq_pkg::ACT_SEARCH) && walk_more)
        begin
            idx_next      = idx_reg + 1'b1;
            rd_valid_next = 1'b1;
            rd_idx_next   = idx_reg[AW-1:0];
        end

        unique case (uw.act)
            uapq_pkg::ACT_WAIT:
            begin
                if (start)
                begin
                    cmd_next  = uapq_pkg::cmd_t'(command);
                    val_next  = element_value;
                    prio_next = priority_value;
                    idx_next  = '0;
                    kept_next = '0;
                    pend_next = 1'b0;
                    hit_next  = 1'b0;
                end
            end
            uapq_pkg::ACT_ADD:
            begin
                res_valid_next = 1'b1;
                last_next      = 1'b1;
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    status_next = uapq_pkg::ST_FULL;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = count_reg[AW-1:0];
                    mem_wdata.value = val_reg;
                    mem_wdata.prio  = prio_reg;
                    count_next      = count_reg + 1'b1;
                    status_next     = uapq_pkg::ST_ADDED;
                end
            end
            uapq_pkg::ACT_NOP:
            begin
            end
            uapq_pkg::ACT_SCAN:
            begin
                // Strictly greater keeps the earliest entry among equal priorities.
                if (rd_valid_reg && (rd_idx_reg == '0 ||
                    $signed(rd_data_reg.prio) > $signed(best_prio_reg)))
                begin
                    best_idx_next  = rd_idx_reg;
                    best_prio_next = rd_data_reg.prio;
                end
            end
            uapq_pkg::ACT_REWIND:
            begin
                idx_next  = '0;
                kept_next = '0;
                pend_next = 1'b0;
            end
            uapq_pkg::ACT_COMPACT:
            begin
                if (rd_valid_reg)
                begin
                    if (remove)
                    begin
                        // A removed entry is held back so the final one can carry last.
                        if (pend_reg)
                        begin
                            res_valid_next = 1'b1;
                            status_next    = uapq_pkg::ST_EXTRACTED;
                            out_elem_next  = pend_data_reg.value;
                            out_prio_next  = pend_data_reg.prio;
                        end
                        pend_next      = 1'b1;
                        pend_data_next = rd_data_reg;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = kept_reg[AW-1:0];
                        mem_wdata = rd_data_reg;
                        kept_next = kept_reg + 1'b1;
                    end
                end
            end
            uapq_pkg::ACT_FINISH:
            begin
                count_next     = kept_reg;
                res_valid_next = 1'b1;
                last_next      = 1'b1;
                if (pend_reg)
                begin
                    status_next   = uapq_pkg::ST_EXTRACTED;
                    out_elem_next = pend_data_reg.value;
                    out_prio_next = pend_data_reg.prio;
                end
                else
                begin
                    status_next = uapq_pkg::ST_NONE;
                end
                pend_next = 1'b0;
            end
            uapq_pkg::ACT_SEARCH:
            begin
                if (rd_valid_reg && rd_data_reg.value == val_reg)
                begin
                    hit_next = 1'b1;
                end
            end
            uapq_pkg::ACT_REPORT:
            begin
                res_valid_next = 1'b1;
                status_next    = uapq_pkg::ST_CONTAINS;
                found_next     = hit_reg;
                last_next      = 1'b1;
            end
            uapq_pkg::ACT_EMPTY:
            begin
                res_valid_next = 1'b1;
                status_next    = uapq_pkg::ST_EMPTY;
                last_next      = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= uapq_pkg::STEP_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        prio_reg      <= prio_next;
        idx_reg       <= idx_next;
        kept_reg      <= kept_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        pend_data_reg <= pend_data_next;
        hit_reg       <= hit_next;
        status_reg    <= status_next;
        out_elem_reg  <= out_elem_next;
        out_prio_reg  <= out_prio_next;
        found_reg     <= found_next;
        last_reg      <= last_next;
    end

    // Result port.
    assign busy         = (upc_reg != uapq_pkg::STEP_IDLE);
    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign out_element  = out_elem_reg;
    assign out_priority = out_prio_reg;
    assign found        = found_reg;
    assign last         = last_reg;

endmodule
